>>> sv/wbps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wildcard byte pattern scanner.
// Used by wbps_match, wildcard_byte_pattern_scan and wbps_checker.
package wbps_pkg;

   // Default sizes handed to the top level parameters
   localparam int PATTERN_MAX_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;

   // Fixed field widths
   localparam int SIG_BYTES = 16;           // signature bytes held by the registers
   localparam int SIG_IDX_W = 4;            // index into the signature bytes
   localparam int LEN_W     = 5;            // pattern_length register width
   localparam int ADDR_W    = 64;           // address width
   localparam int CSR_IDX_W = 3;            // register index width
   localparam int CSR_DAT_W = 64;           // widest register

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_BASE_ADDRESS   = 3'd4,
      CSR_REPORT_END     = 3'd5
   } csr_index_type;

   // Signature setup seen by the compare unit
   typedef struct packed {
      logic [SIG_BYTES-1:0][7:0] sig;       // byte n at sig[n]
      logic [SIG_BYTES-1:0]      care;      // 1: byte must match
      logic [LEN_W-1:0]          len;       // positions in use, already clamped
   } match_cfg_type;

endpackage

>>> sv/wildcard_byte_pattern_scan.sv
`timescale 1ns / 1ps
// Top level of the wildcard byte pattern scanner: registers, window, offset, result.
// Depends on wbps_pkg and wbps_match.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_image_byte, req_last_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_found, rsp_match_address
//   csr      in         csr_write_en         csr_index, csr_data
//
// One byte per cycle while req_stall is low; an accepted byte passes the input register,
// then window update and compare into the result register.
// Throughput rests on the window shift and masked compare, which are combinational.
// Reset is synchronous: registers return to their defaults and the scan rearms.
// rsp_stall holds the result; req_stall rises only while the input register
// holds a word and the result register is full and stalled.
module wildcard_byte_pattern_scan #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_image_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [wbps_pkg::ADDR_W-1:0]    rsp_match_address,
   input  logic                           csr_write_en,
   input  logic [wbps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wbps_pkg::CSR_DAT_W-1:0] csr_data
);
   import wbps_pkg::*;

   // Configuration registers
   logic [63:0]       pat_low_ff, pat_high_ff, base_ff;
   logic [15:0]       care_ff;
   logic [LEN_W-1:0]  plen_ff;
   logic              rep_end_ff;

   // Input register
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   logic              s1_last_ff;
   logic              s1_go;

   // Scan state
   logic [PATTERN_MAX-1:0][7:0] win_ff, win_in, win_shift;
   logic [OFFSET_BITS-1:0]      off_ff, off_in, off_next;
   logic                        done_ff, done_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic [LEN_W-1:0]       len_eff;
   logic [OFFSET_BITS-1:0] len_off;
   match_cfg_type          mcfg;
   logic                   cmp_hit, hit;
   logic [ADDR_W-1:0]      match_addr;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         plen_ff     <= LEN_W'(1);
         base_ff     <= '0;
         rep_end_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH:   pat_high_ff <= csr_data;
            CSR_CARE_MASK:      care_ff     <= csr_data[15:0];
            CSR_PATTERN_LENGTH: plen_ff     <= csr_data[LEN_W-1:0];
            CSR_BASE_ADDRESS:   base_ff     <= csr_data;
            CSR_REPORT_END:     rep_end_ff  <= csr_data[0];
            default:            ;
         endcase
      end
   end

   // Clamp the length and pack the compare setup
   assign len_eff   = (plen_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_ff;
   assign len_off   = OFFSET_BITS'(len_eff);
   assign mcfg.sig  = {pat_high_ff, pat_low_ff};
   assign mcfg.care = care_ff;
   assign mcfg.len  = len_eff;

   // Advance the input word when the result slot is free or being drained
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_image_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // Shift the new byte into the window
   assign win_shift[0] = s1_byte_ff;
   for (genvar j = 1; j < PATTERN_MAX; j++) begin : g_shift
      assign win_shift[j] = win_ff[j-1];
   end

   // Saturating byte count
   assign off_next = (off_ff == {OFFSET_BITS{1'b1}}) ? off_ff : off_ff + OFFSET_BITS'(1);

   wbps_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .cfg_i (mcfg),
      .win_i (win_shift),
      .hit_o (cmp_hit)
   );

   assign hit        = cmp_hit && (off_next >= len_off);
   assign match_addr = base_ff + ADDR_W'(rep_end_ff ? off_next : off_next - len_off);

   // Update scan state and build the result
   always_comb begin
      win_in       = win_ff;
      off_in       = off_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (s1_go) begin
         if (!done_ff) begin
            win_in = win_shift;
            off_in = off_next;
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_addr_in  = match_addr;
               done_in      = 1'b1;
            end else if (s1_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_addr_in  = '0;
            end
         end
         // Last byte rearms the scan
         if (s1_last_ff) begin
            win_in  = '0;
            off_in  = '0;
            done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         off_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         off_ff       <= off_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

endmodule

>>> sv/wbps_match.sv
`timescale 1ns / 1ps
// Parallel masked compare of the byte window against the signature.
// Depends on wbps_pkg for match_cfg_type and the field widths.
module wbps_match #(
   parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
   input  wbps_pkg::match_cfg_type     cfg_i,
   input  logic [PATTERN_MAX-1:0][7:0] win_i,   // newest byte at index 0
   output logic                        hit_o
);
   import wbps_pkg::*;

   logic [PATTERN_MAX-1:0][SIG_IDX_W-1:0] pos_k;
   logic [PATTERN_MAX-1:0]                pos_ok;

   // Window position j holds signature position len-1-j
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
      assign pos_k[j]  = SIG_IDX_W'(cfg_i.len - LEN_W'(j + 1));
      assign pos_ok[j] = (LEN_W'(j) >= cfg_i.len) || !cfg_i.care[pos_k[j]] ||
                         (cfg_i.sig[pos_k[j]] == win_i[j]);
   end

   // Empty signature never matches
   assign hit_o = (cfg_i.len != '0) && (&pos_ok);

endmodule

>>> sv/wbps_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for wildcard_byte_pattern_scan, with the bind that attaches them.
// Depends on wbps_pkg for the port widths.
module wbps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_found,
   input logic [wbps_pkg::ADDR_W-1:0] rsp_match_address
);
   import wbps_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) &&
                                 $stable(rsp_match_address))
      else $error("stalled result word changed");

   // A miss reports address zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_address == '0)
      else $error("miss result with nonzero address");

   // Reset drops the result and opens the input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the channels");

   // A fresh result comes from an accepted input word, through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without an accepted input word");

   // Input never stalls while the result slot is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result slot");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_found         (rsp_found),
   .rsp_match_address (rsp_match_address)
);
